// ===== hw/rtl/atr_pkg.sv =====
package atr_pkg;

  // field widths fixed by the stream format
  localparam int SAMPLE_W  = 16;
  localparam int ANGLE_W   = 15;
  localparam int IN_DATA_W = 48;
  localparam int OUT_DATA_W = 32;

  // defaults for the top level parameters
  localparam int ANGLE_FRAC_BITS_DEF = 7;
  localparam int CORDIC_STAGES_DEF   = 16;

  // root and table precision
  localparam int ROOT_W     = 30;
  localparam int TAB_FRAC   = 16;
  localparam int TAB_W      = 24;
  localparam int ANG_RES_W  = 20;

  // atan(2^-i) in degrees, 16 fraction bits, rounded to nearest
  function automatic logic [TAB_W-1:0] atr_atan_deg(input int i);
    logic [TAB_W-1:0] v;
    case (i)
      0:  v = 24'd2949120;
      1:  v = 24'd1740967;
      2:  v = 24'd919879;
      3:  v = 24'd466945;
      4:  v = 24'd234379;
      5:  v = 24'd117304;
      6:  v = 24'd58666;
      7:  v = 24'd29335;
      8:  v = 24'd14668;
      9:  v = 24'd7334;
      10: v = 24'd3667;
      11: v = 24'd1833;
      12: v = 24'd917;
      13: v = 24'd458;
      14: v = 24'd229;
      15: v = 24'd115;
      16: v = 24'd57;
      17: v = 24'd29;
      18: v = 24'd14;
      19: v = 24'd7;
      20: v = 24'd4;
      21: v = 24'd2;
      22: v = 24'd1;
      default: v = 24'd0;
    endcase
    return v;
  endfunction

endpackage

// ===== hw/rtl/accel_tilt_roll_pitch_core.sv =====
// roll and pitch from one raw accelerometer reading
// input word: six bytes, low and high for each of x, y and z; each pair forms
// a signed 16-bit sample. result word: roll and pitch in degrees with
// ANGLE_FRAC_BITS fraction bits, signed 15 bit, range +-90 degrees.
// roll = atan2(y, sqrt(x^2+z^2)), pitch = -atan2(x, sqrt(y^2+z^2)).
// both angles run through their own pipeline: squares, sum, a 30-stage
// square root (one root bit per stage), a CORDIC_STAGES-deep vectoring
// cordic, a rounding stage and the output register.
// one word is accepted every cycle unless a result waits with out_tready low.
// when out_tready is low while a result waits, the whole pipeline holds and
// in_tready drops in the same cycle; nothing is lost or repeated.
// reset clears the valid bits of every stage; data registers are not reset.
module accel_tilt_roll_pitch_core #(
  parameter int ANGLE_FRAC_BITS = atr_pkg::ANGLE_FRAC_BITS_DEF,
  parameter int CORDIC_STAGES   = atr_pkg::CORDIC_STAGES_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // x_low, x_high, y_low, y_high, z_low, z_high
  input  logic [atr_pkg::IN_DATA_W-1:0]     in_tdata,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // roll_angle, pitch_angle, zero pad
  output logic [atr_pkg::OUT_DATA_W-1:0]    out_tdata
);
  import atr_pkg::*;

  localparam int LAT     = 2 + ROOT_W + CORDIC_STAGES + 1;
  localparam int LIM     = 90 * (2 ** ANGLE_FRAC_BITS);
  localparam int OUT_MAX = 16383;
  localparam int LIM_OUT = (LIM < OUT_MAX) ? LIM : OUT_MAX;
  localparam int LIM_LO  = (LIM < OUT_MAX) ? -LIM : -OUT_MAX - 1;

  logic                        ce;
  logic                        vld_r [0:LAT];
  logic signed [SAMPLE_W-1:0]  xs, ys, zs;
  logic signed [ANG_RES_W-1:0] roll_a, pitch_a;
  logic [ANGLE_W-1:0]          roll_nxt, pitch_nxt, roll_r, pitch_r;

  // pipeline moves unless a result is waiting on the receiver
  assign ce        = !vld_r[LAT] || out_tready;
  assign in_tready = ce;

  // join bytes into samples
  assign xs = signed'(in_tdata[15:0]);
  assign ys = signed'(in_tdata[31:16]);
  assign zs = signed'(in_tdata[47:32]);

  atr_tilt #(
    .ANGLE_FRAC_BITS(ANGLE_FRAC_BITS),
    .CORDIC_STAGES  (CORDIC_STAGES)
  ) u_roll (
    .clk  (clk),
    .ce   (ce),
    .a    (ys),
    .p    (xs),
    .q    (zs),
    .angle(roll_a)
  );

  atr_tilt #(
    .ANGLE_FRAC_BITS(ANGLE_FRAC_BITS),
    .CORDIC_STAGES  (CORDIC_STAGES)
  ) u_pitch (
    .clk  (clk),
    .ce   (ce),
    .a    (xs),
    .p    (ys),
    .q    (zs),
    .angle(pitch_a)
  );

  // saturate to the signed 15-bit field
  function automatic logic [ANGLE_W-1:0] sat15(input logic signed [ANG_RES_W:0] v);
    logic [ANGLE_W-1:0] r;
    if (v > (ANG_RES_W+1)'(OUT_MAX)) begin
      r = ANGLE_W'(OUT_MAX);
    end else if (v < -(ANG_RES_W+1)'(OUT_MAX + 1)) begin
      r = ANGLE_W'(-(OUT_MAX + 1));
    end else begin
      r = v[ANGLE_W-1:0];
    end
    return r;
  endfunction

  assign roll_nxt  = sat15((ANG_RES_W+1)'(roll_a));
  assign pitch_nxt = sat15(-(ANG_RES_W+1)'(pitch_a));

  // valid bits travel with the data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k <= LAT; k++) begin
        vld_r[k] <= 1'b0;
      end
    end else if (ce) begin
      vld_r[0] <= in_tvalid;
      for (int k = 1; k <= LAT; k++) begin
        vld_r[k] <= vld_r[k-1];
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (ce) begin
      roll_r  <= roll_nxt;
      pitch_r <= pitch_nxt;
    end
  end

  assign out_tvalid = vld_r[LAT];
  assign out_tdata  = {{(OUT_DATA_W-2*ANGLE_W){1'b0}}, pitch_r, roll_r};

`ifndef NO_ASSERTIONS
  a_roll_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> ($signed(roll_r) <= 16'(LIM_OUT) &&
                    $signed(roll_r) >= 16'(LIM_LO)))
    else $error("roll outside +-90 degrees");
  a_pitch_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> ($signed(pitch_r) <= 16'(LIM_OUT) &&
                    $signed(pitch_r) >= 16'(LIM_LO)))
    else $error("pitch outside +-90 degrees");
  a_hold_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("waiting result changed under stall");
  a_stall_freeze: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |=> $stable(vld_r[0]) && $stable(vld_r[LAT-1]))
    else $error("pipeline moved while stalled");
`endif

endmodule

// ===== hw/rtl/atr_tilt.sv =====
module atr_tilt #(
  parameter int ANGLE_FRAC_BITS = atr_pkg::ANGLE_FRAC_BITS_DEF,
  parameter int CORDIC_STAGES   = atr_pkg::CORDIC_STAGES_DEF
) (
  input  logic                                clk,
  input  logic                                ce,
  input  logic signed [atr_pkg::SAMPLE_W-1:0] a,
  input  logic signed [atr_pkg::SAMPLE_W-1:0] p,
  input  logic signed [atr_pkg::SAMPLE_W-1:0] q,
  output logic signed [atr_pkg::ANG_RES_W-1:0] angle
);
  import atr_pkg::*;

  localparam int SQ_W  = 32;
  localparam int REM_W = 34;
  localparam int XY_W  = 34;
  localparam int Z_W   = TAB_W + 1;
  localparam int SH    = TAB_FRAC - ANGLE_FRAC_BITS;
  localparam int LIM   = 90 * (2 ** ANGLE_FRAC_BITS);

  // flags that ride along: numerator zero, numerator negative, radicand zero
  typedef struct packed {
    logic a_zero;
    logic a_neg;
    logic sq_zero;
  } atr_flags_t;

  // stage a: squares
  logic [SQ_W-1:0]              pp_r, qq_r;
  logic signed [SAMPLE_W-1:0]   a_a_r;
  logic signed [2*SAMPLE_W-1:0] pp_full, qq_full;

  assign pp_full = p * p;
  assign qq_full = q * q;

  always_ff @(posedge clk) begin
    if (ce) begin
      pp_r  <= unsigned'(pp_full);
      qq_r  <= unsigned'(qq_full);
      a_a_r <= a;
    end
  end

  // stage b: sum of squares, sqrt pipeline head
  logic [SQ_W-1:0]            sq_s   [0:ROOT_W];
  logic [REM_W-1:0]           rem_s  [0:ROOT_W];
  logic [ROOT_W-1:0]          root_s [0:ROOT_W];
  logic signed [SAMPLE_W-1:0] a_s    [0:ROOT_W];
  atr_flags_t                 fl_s   [0:ROOT_W];

  always_ff @(posedge clk) begin
    if (ce) begin
      sq_s[0]   <= pp_r + qq_r;
      rem_s[0]  <= '0;
      root_s[0] <= '0;
      a_s[0]    <= a_a_r;
      fl_s[0]   <= '{a_zero: (a_a_r == '0), a_neg: a_a_r[SAMPLE_W-1],
                     sq_zero: ((pp_r | qq_r) == '0)};
    end
  end

  // restoring square root of sq << 28, one root bit per stage
  for (genvar j = 0; j < ROOT_W; j++) begin : g_sqrt
    localparam int K = ROOT_W - 1 - j;
    logic [1:0]       pair;
    logic [REM_W-1:0] rem_in, trial;
    logic             take;

    if (2 * K >= 28) begin : g_bits
      assign pair = sq_s[j][2*K-28 +: 2];
    end else begin : g_zero
      assign pair = 2'b00;
    end

    assign rem_in = {rem_s[j][REM_W-3:0], pair};
    assign trial  = {{(REM_W-ROOT_W-2){1'b0}}, root_s[j], 2'b01};
    assign take   = (rem_in >= trial);

    always_ff @(posedge clk) begin
      if (ce) begin
        sq_s[j+1]   <= sq_s[j];
        rem_s[j+1]  <= take ? rem_in - trial : rem_in;
        root_s[j+1] <= {root_s[j][ROOT_W-2:0], take};
        a_s[j+1]    <= a_s[j];
        fl_s[j+1]   <= fl_s[j];
      end
    end
  end

  // vectoring cordic, one micro-rotation per stage
  logic signed [XY_W-1:0] x_c [0:CORDIC_STAGES];
  logic signed [XY_W-1:0] y_c [0:CORDIC_STAGES];
  logic signed [Z_W-1:0]  z_c [0:CORDIC_STAGES];
  atr_flags_t             fl_c [0:CORDIC_STAGES];

  assign x_c[0]  = signed'({{(XY_W-ROOT_W){1'b0}}, root_s[ROOT_W]});
  assign y_c[0]  = signed'({{(XY_W-SAMPLE_W-14){a_s[ROOT_W][SAMPLE_W-1]}},
                            a_s[ROOT_W], 14'b0});
  assign z_c[0]  = '0;
  assign fl_c[0] = fl_s[ROOT_W];

  for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cordic
    logic signed [XY_W-1:0] dx, dy;
    logic signed [Z_W-1:0]  ang;

    assign dx  = y_c[i] >>> i;
    assign dy  = x_c[i] >>> i;
    assign ang = signed'({1'b0, atr_atan_deg(i)});

    always_ff @(posedge clk) begin
      if (ce) begin
        if (!y_c[i][XY_W-1]) begin
          x_c[i+1] <= x_c[i] + dx;
          y_c[i+1] <= y_c[i] - dy;
          z_c[i+1] <= z_c[i] + ang;
        end else begin
          x_c[i+1] <= x_c[i] - dx;
          y_c[i+1] <= y_c[i] + dy;
          z_c[i+1] <= z_c[i] - ang;
        end
        fl_c[i+1] <= fl_c[i];
      end
    end
  end

  // round half away from zero, clamp, special cases
  logic [Z_W-1:0]           z_mag, z_rnd;
  logic [Z_W-1:0]           m_clp;
  logic signed [ANG_RES_W-1:0] ang_nxt, angle_r;
  atr_flags_t               fl_f;

  assign fl_f  = fl_c[CORDIC_STAGES];
  assign z_mag = z_c[CORDIC_STAGES][Z_W-1] ? unsigned'(-z_c[CORDIC_STAGES])
                                           : unsigned'(z_c[CORDIC_STAGES]);
  assign z_rnd = (z_mag + Z_W'(2 ** (SH - 1))) >> SH;
  assign m_clp = (z_rnd > Z_W'(LIM)) ? Z_W'(LIM) : z_rnd;

  always_comb begin
    if (fl_f.a_zero) begin
      ang_nxt = '0;
    end else if (fl_f.sq_zero) begin
      ang_nxt = fl_f.a_neg ? -ANG_RES_W'(LIM) : ANG_RES_W'(LIM);
    end else if (z_c[CORDIC_STAGES][Z_W-1]) begin
      ang_nxt = -signed'(m_clp[ANG_RES_W-1:0]);
    end else begin
      ang_nxt = signed'(m_clp[ANG_RES_W-1:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      angle_r <= ang_nxt;
    end
  end

  assign angle = angle_r;

endmodule
